FILE: sv/psl_pkg.sv
package psl_pkg;

  localparam int AlfaLength = 10;
  localparam int LenW = 4;

  localparam logic [5:0] K_IDENT = 6'd0;
  localparam logic [5:0] K_INT   = 6'd1;
  localparam logic [5:0] K_CHAR  = 6'd2;
  localparam logic [5:0] K_BECOMES = 6'd3;
  localparam logic [5:0] K_COLON = 6'd4;
  localparam logic [5:0] K_RANGE = 6'd5;
  localparam logic [5:0] K_PERIOD = 6'd6;
  localparam logic [5:0] K_LE    = 6'd7;
  localparam logic [5:0] K_NE    = 6'd8;
  localparam logic [5:0] K_LT    = 6'd9;
  localparam logic [5:0] K_GE    = 6'd10;
  localparam logic [5:0] K_GT    = 6'd11;
  localparam logic [5:0] K_SINGLE = 6'd12;
  localparam logic [5:0] K_OTHER = 6'd22;
  localparam logic [5:0] K_KEYWORD = 6'd23;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_OVERFLOW = 2'd1;
  localparam logic [1:0] E_CHAR = 2'd2;

  localparam logic [7:0] QUOTE = 8'h27;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] value;
    logic [79:0] spelling;
    logic [1:0]  err;
    logic        last;
  } token_t;

  typedef logic [79:0] kw_row_t;

  function automatic kw_row_t kw_text(input logic [4:0] i);
    kw_row_t r;
    r = '0;
    case (i)
      5'd0:  r[55:0] = {"MARGORP"};
      5'd1:  r[71:0] = {"ERUDECORP"};
      5'd2:  r[23:0] = {"RAV"};
      5'd3:  r[39:0] = {"YARRA"};
      5'd4:  r[39:0] = {"NIGEB"};
      5'd5:  r[23:0] = {"DNE"};
      5'd6:  r[31:0] = {"DAER"};
      5'd7:  r[39:0] = {"ETIRW"};
      5'd8:  r[15:0] = {"OD"};
      5'd9:  r[39:0] = {"ELIHW"};
      5'd10: r[15:0] = {"FI"};
      5'd11: r[31:0] = {"NEHT"};
      5'd12: r[31:0] = {"ESLE"};
      5'd13: r[15:0] = {"RO"};
      5'd14: r[23:0] = {"DNA"};
      5'd15: r[23:0] = {"TON"};
      5'd16: r[15:0] = {"FO"};
      5'd17: r[23:0] = {"VID"};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/psl_front.sv
module psl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [30:0]          cfg_wdata,
  input  logic                 take,
  input  logic [7:0]           char_in,
  input  logic                 end_of_text,
  output logic [1:0]           n_tok,
  output psl_pkg::token_t      tok0,
  output psl_pkg::token_t      tok1
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_COLON, M_PERIOD, M_LT, M_GT,
    M_CH_OPEN, M_CH_QQ, M_CH_CLOSE
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic [79:0] spell_r, spell_nxt;
  logic [psl_pkg::LenW-1:0] len_r, len_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [1:0] perr_r, perr_nxt;
  logic [30:0] maxq_r;
  logic [3:0] maxr_r;
  logic [63:0] recip;
  logic [30:0] cfg_q;

  // The limit is split into quotient and remainder by ten with a reciprocal multiply.
  assign recip = {33'd0, cfg_wdata} * 64'h0000_0000_CCCC_CCCD;
  assign cfg_q = {2'b00, recip[63:35]};

  function automatic logic is_letter(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic psl_pkg::token_t mk(input logic [5:0] k, input logic [30:0] v,
                                         input logic [1:0] e);
    psl_pkg::token_t t;
    t = '0;
    t.kind = k;
    t.value = v;
    t.err = e;
    return t;
  endfunction

  always_comb begin
    psl_pkg::token_t t[2];
    logic [1:0] n;
    logic rescan;
    logic [5:0] kw;
    logic [7:0] c;
    logic [3:0] d;
    logic [34:0] times10;
    c = char_in;
    d = c[3:0];
    t[0] = '0;
    t[1] = '0;
    n = 2'd0;
    rescan = 1'b0;
    mode_nxt = mode_r;
    spell_nxt = spell_r;
    len_nxt = len_r;
    acc_nxt = acc_r;
    perr_nxt = perr_r;
    kw = psl_pkg::K_IDENT;
    for (int i = 0; i < 18; i++) begin
      if (kw == psl_pkg::K_IDENT && spell_r == psl_pkg::kw_text(5'(i))) begin
        kw = psl_pkg::K_KEYWORD + 6'(i);
      end
    end
    times10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
    if (end_of_text || !(
        (mode_r == M_IDENT && (is_letter(c) || is_digit(c))) ||
        (mode_r == M_INT && is_digit(c)) ||
        (mode_r == M_COLON && c == "=") ||
        (mode_r == M_PERIOD && c == ".") ||
        (mode_r == M_LT && (c == "=" || c == ">")) ||
        (mode_r == M_GT && c == "=") ||
        mode_r == M_CH_OPEN || mode_r == M_CH_QQ ||
        (mode_r == M_CH_CLOSE && c == psl_pkg::QUOTE) ||
        mode_r == M_IDLE)) begin
      unique case (mode_r)
        M_IDENT: begin
          t[0] = mk(kw, '0, psl_pkg::E_NONE);
          t[0].spelling = spell_r;
          n = 2'd1;
        end
        M_INT: begin t[0] = mk(psl_pkg::K_INT, acc_r, perr_r); n = 2'd1; end
        M_COLON: begin t[0] = mk(psl_pkg::K_COLON, '0, '0); n = 2'd1; end
        M_PERIOD: begin t[0] = mk(psl_pkg::K_PERIOD, '0, '0); n = 2'd1; end
        M_LT: begin t[0] = mk(psl_pkg::K_LT, '0, '0); n = 2'd1; end
        M_GT: begin t[0] = mk(psl_pkg::K_GT, '0, '0); n = 2'd1; end
        M_CH_OPEN, M_CH_QQ, M_CH_CLOSE: begin
          t[0] = mk(psl_pkg::K_CHAR, acc_r, psl_pkg::E_CHAR);
          n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      mode_nxt = M_IDLE;
      perr_nxt = psl_pkg::E_NONE;
      rescan = !end_of_text;
    end else begin
      unique case (mode_r)
        M_IDENT: begin
          if (len_r < psl_pkg::LenW'(psl_pkg::AlfaLength)) begin
            spell_nxt[len_r*8 +: 8] = c;
            len_nxt = len_r + 1'b1;
          end
        end
        M_INT: begin
          if (acc_r < maxq_r || (acc_r == maxq_r && d <= maxr_r)) begin
            acc_nxt = 31'(times10 + 35'(d));
          end else begin
            perr_nxt = psl_pkg::E_OVERFLOW;
            acc_nxt = '0;
          end
        end
        M_COLON: begin
          t[0] = mk(psl_pkg::K_BECOMES, '0, '0); n = 2'd1; mode_nxt = M_IDLE;
        end
        M_PERIOD: begin
          t[0] = mk(psl_pkg::K_RANGE, '0, '0); n = 2'd1; mode_nxt = M_IDLE;
        end
        M_LT: begin
          t[0] = mk((c == "=") ? psl_pkg::K_LE : psl_pkg::K_NE, '0, '0);
          n = 2'd1;
          mode_nxt = M_IDLE;
        end
        M_GT: begin
          t[0] = mk(psl_pkg::K_GE, '0, '0); n = 2'd1; mode_nxt = M_IDLE;
        end
        M_CH_OPEN: begin
          if (c == psl_pkg::QUOTE) begin
            mode_nxt = M_CH_QQ;
          end else begin
            acc_nxt = 31'(c);
            mode_nxt = M_CH_CLOSE;
          end
        end
        M_CH_QQ: begin
          if (c != psl_pkg::QUOTE) perr_nxt = psl_pkg::E_CHAR;
          acc_nxt = 31'(c);
          mode_nxt = M_CH_CLOSE;
        end
        M_CH_CLOSE: begin
          t[0] = mk(psl_pkg::K_CHAR, acc_r, perr_r);
          n = 2'd1;
          mode_nxt = M_IDLE;
          perr_nxt = psl_pkg::E_NONE;
        end
        default: rescan = 1'b1;
      endcase
    end
    if (rescan && !(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)) begin
      spell_nxt = '0;
      len_nxt = '0;
      acc_nxt = '0;
      perr_nxt = psl_pkg::E_NONE;
      if (is_letter(c)) begin
        spell_nxt[7:0] = c;
        len_nxt = psl_pkg::LenW'(1);
        mode_nxt = M_IDENT;
      end else if (is_digit(c)) begin
        if (maxq_r != '0 || d <= maxr_r) acc_nxt = 31'(d);
        else perr_nxt = psl_pkg::E_OVERFLOW;
        mode_nxt = M_INT;
      end else if (c == psl_pkg::QUOTE) mode_nxt = M_CH_OPEN;
      else if (c == ":") mode_nxt = M_COLON;
      else if (c == ".") mode_nxt = M_PERIOD;
      else if (c == "<") mode_nxt = M_LT;
      else if (c == ">") mode_nxt = M_GT;
      else begin
        t[n[0]] = mk(psl_pkg::K_OTHER, '0, '0);
        case (c)
          "+": t[n[0]].kind = psl_pkg::K_SINGLE;
          "-": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd1;
          "*": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd2;
          "=": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd3;
          "(": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd4;
          ")": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd5;
          "[": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd6;
          "]": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd7;
          ",": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd8;
          ";": t[n[0]].kind = psl_pkg::K_SINGLE + 6'd9;
          default: t[n[0]].kind = psl_pkg::K_OTHER;
        endcase
        n = n + 2'd1;
      end
    end
    if (n == 2'd1) t[0].last = 1'b1;
    if (n == 2'd2) t[1].last = 1'b1;
    n_tok = n;
    tok0 = t[0];
    tok1 = t[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      spell_r <= '0;
      len_r <= '0;
      acc_r <= '0;
      perr_r <= '0;
      maxq_r <= 31'd3276;
      maxr_r <= 4'd7;
    end else begin
      if (cfg_we) begin
        maxq_r <= cfg_q;
        maxr_r <= cfg_wdata[3:0] - {cfg_q[0], 3'b000} - {cfg_q[2:0], 1'b0};
      end
      if (take) begin
        mode_r <= mode_nxt;
        spell_r <= spell_nxt;
        len_r <= len_nxt;
        acc_r <= acc_nxt;
        perr_r <= perr_nxt;
      end
    end
  end

endmodule

FILE: sv/psl_queue.sv
module psl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [1:0]      n_push,
  input  psl_pkg::token_t tok0,
  input  psl_pkg::token_t tok1,
  output logic            room2,
  input  logic            pop,
  output logic            empty,
  output psl_pkg::token_t head
);

  psl_pkg::token_t mem_r [4];
  logic [2:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [2:0] cnt;

  assign cnt = wp_r - rp_r;
  assign room2 = cnt <= 3'd2;
  assign empty = cnt == 3'd0;
  assign head = mem_r[rp_r[1:0]];
  assign wp_nxt = wp_r + (push ? 3'(n_push) : 3'd0);
  assign rp_nxt = rp_r + ((pop && !empty) ? 3'd1 : 3'd0);

  always_ff @(posedge clk) begin
    if (push && n_push != 2'd0) mem_r[wp_r[1:0]] <= tok0;
    if (push && n_push == 2'd2) mem_r[2'(wp_r[1:0] + 2'd1)] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

endmodule

FILE: sv/pascal_subset_lexer_unit.sv
// Channel  | Ports                               | Accepted when
// input    | in_char_in, in_end_of_text          | push && !full
// result   | out_token_kind .. out_last_of_run   | pop && !empty
// config   | cfg_we, cfg_max_integer             | cfg_we
// One byte is taken per cycle unless full; its tokens enter a four-entry queue in the
// same edge. The oldest token is on the result ports the cycle after; full rises when
// the queue cannot take two more tokens. Reset is synchronous and empties the queue.
module pascal_subset_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [30:0] cfg_max_integer,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_token_kind,
  output logic [30:0] out_const_value,
  output logic [63:0] out_spelling_first,
  output logic [15:0] out_spelling_rest,
  output logic [1:0]  out_error_code,
  output logic        out_last_of_run
);

  logic take, room2;
  logic [1:0] n_tok;
  psl_pkg::token_t tok0, tok1, head;

  assign full = !room2;
  assign take = push && room2;

  psl_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata(cfg_max_integer), .take,
    .char_in(in_char_in), .end_of_text(in_end_of_text), .n_tok, .tok0, .tok1
  );

  psl_queue u_queue (
    .clk, .rst_n, .push(take), .n_push(n_tok), .tok0, .tok1, .room2,
    .pop, .empty, .head
  );

  assign out_token_kind = head.kind;
  assign out_const_value = head.value;
  assign out_spelling_first = head.spelling[63:0];
  assign out_spelling_rest = head.spelling[79:64];
  assign out_error_code = head.err;
  assign out_last_of_run = head.last;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !take) else $error("item taken while full");
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full) else $error("full dropped without a pop");
  a_two_means_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && n_tok == 2'd2) |-> (tok1.last && !tok0.last)) else $error("run marks");

endmodule

FILE: tb/sv/tb_pascal_subset_lexer_unit.sv
`timescale 1ns / 1ps

module tb_pascal_subset_lexer_unit;

  typedef enum {
    M_IDLE, M_IDENT, M_INT, M_COLON, M_PERIOD, M_LT, M_GT,
    M_CH_OPEN, M_CH_QQ, M_CH_CLOSE
  } lex_mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [30:0] value;
    logic [63:0] first;
    logic [15:0] rest;
    logic [1:0]  err;
    logic        last;
  } exp_tok_t;

  typedef struct {
    logic [7:0]  c;
    logic        eot;
    bit          chk;
    logic [5:0]  kind;
    logic [30:0] value;
    logic [1:0]  err;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [30:0] cfg_max_integer;
  logic        push;
  logic        full;
  logic [7:0]  in_char_in;
  logic        in_end_of_text;
  logic        empty;
  logic        pop;
  logic [5:0]  out_token_kind;
  logic [30:0] out_const_value;
  logic [63:0] out_spelling_first;
  logic [15:0] out_spelling_rest;
  logic [1:0]  out_error_code;
  logic        out_last_of_run;

  pascal_subset_lexer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_max_integer(cfg_max_integer),
    .push(push), .full(full),
    .in_char_in(in_char_in), .in_end_of_text(in_end_of_text),
    .empty(empty), .pop(pop),
    .out_token_kind(out_token_kind), .out_const_value(out_const_value),
    .out_spelling_first(out_spelling_first), .out_spelling_rest(out_spelling_rest),
    .out_error_code(out_error_code), .out_last_of_run(out_last_of_run)
  );

  exp_tok_t    token_q[$];
  exp_tok_t    step_toks[$];
  lex_mode_t   lx_mode;
  logic [7:0]  lx_spell[10];
  int          lx_len;
  logic [30:0] lx_acc;
  logic [1:0]  lx_err;
  logic [30:0] lx_max;

  string kw_names[18] = '{"PROGRAM", "PROCEDURE", "VAR", "ARRAY", "BEGIN", "END",
                          "READ", "WRITE", "DO", "WHILE", "IF", "THEN", "ELSE",
                          "OR", "AND", "NOT", "OF", "DIV"};
  string singles = "+-*=()[],;";
  string ops[9] = '{":=", "..", "<=", "<>", ">=", ":", ".", "<", ">"};

  int n_items, n_tokens, n_bad, n_cfg, stall;
  bit hold_req, tx_steady, rx_steady;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic void put_token(logic [5:0] k, logic [30:0] v, bit sp, logic [1:0] e);
    exp_tok_t t;
    int i;
    t = '0;
    t.kind = k;
    t.value = v;
    t.err = e;
    if (sp) begin
      for (i = 0; i < 8; i++) t.first[8*i +: 8] = lx_spell[i];
      t.rest = {lx_spell[9], lx_spell[8]};
    end
    if (step_toks.size() < 2) step_toks.push_back(t);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void keep_char(logic [7:0] c);
    if (lx_len < psl_pkg::AlfaLength) begin
      lx_spell[lx_len] = c;
      lx_len++;
    end
  endfunction

  function automatic void add_digit(logic [7:0] c);
    int unsigned q, r, d;
    q = lx_max / 10;
    r = lx_max % 10;
    d = c - "0";
    if (lx_acc < q || (lx_acc == q && d <= r)) lx_acc = 31'(10 * lx_acc + d);
    else begin
      lx_err = psl_pkg::E_OVERFLOW;
      lx_acc = '0;
    end
  endfunction

  function automatic void emit_word();
    int i, j;
    bit same;
    logic [5:0] k;
    k = psl_pkg::K_IDENT;
    for (i = 0; i < 18; i++) begin
      same = kw_names[i].len() == lx_len;
      for (j = 0; j < lx_len && same; j++) same = kw_names[i][j] == lx_spell[j];
      if (same && k == psl_pkg::K_IDENT) k = psl_pkg::K_KEYWORD + 6'(i);
    end
    put_token(k, '0, 1, psl_pkg::E_NONE);
  endfunction

  function automatic void lex_flush();
    case (lx_mode)
      M_IDENT: emit_word();
      M_INT: put_token(psl_pkg::K_INT, lx_acc, 0, lx_err);
      M_COLON: put_token(psl_pkg::K_COLON, '0, 0, psl_pkg::E_NONE);
      M_PERIOD: put_token(psl_pkg::K_PERIOD, '0, 0, psl_pkg::E_NONE);
      M_LT: put_token(psl_pkg::K_LT, '0, 0, psl_pkg::E_NONE);
      M_GT: put_token(psl_pkg::K_GT, '0, 0, psl_pkg::E_NONE);
      M_CH_OPEN, M_CH_QQ, M_CH_CLOSE: put_token(psl_pkg::K_CHAR, lx_acc, 0, psl_pkg::E_CHAR);
      default: ;
    endcase
    lx_mode = M_IDLE;
    lx_err = psl_pkg::E_NONE;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    int i;
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
    for (i = 0; i < 10; i++) lx_spell[i] = '0;
    lx_len = 0;
    lx_acc = '0;
    lx_err = psl_pkg::E_NONE;
    if (is_letter(c)) begin
      keep_char(c);
      lx_mode = M_IDENT;
    end else if (is_digit(c)) begin
      add_digit(c);
      lx_mode = M_INT;
    end else if (c == psl_pkg::QUOTE) lx_mode = M_CH_OPEN;
    else if (c == ":") lx_mode = M_COLON;
    else if (c == ".") lx_mode = M_PERIOD;
    else if (c == "<") lx_mode = M_LT;
    else if (c == ">") lx_mode = M_GT;
    else begin
      for (i = 0; i < 10; i++) begin
        if (c == singles[i]) begin
          put_token(psl_pkg::K_SINGLE + 6'(i), '0, 0, psl_pkg::E_NONE);
          return;
        end
      end
      put_token(psl_pkg::K_OTHER, '0, 0, psl_pkg::E_NONE);
    end
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eot);
    bit again;
    again = 0;
    step_toks.delete();
    if (eot) lex_flush();
    else begin
      case (lx_mode)
        M_IDENT: if (is_letter(c) || is_digit(c)) keep_char(c);
                 else again = 1;
        M_INT: if (is_digit(c)) add_digit(c);
               else again = 1;
        M_COLON: if (c == "=") begin
          put_token(psl_pkg::K_BECOMES, '0, 0, psl_pkg::E_NONE);
          lx_mode = M_IDLE;
        end else again = 1;
        M_PERIOD: if (c == ".") begin
          put_token(psl_pkg::K_RANGE, '0, 0, psl_pkg::E_NONE);
          lx_mode = M_IDLE;
        end else again = 1;
        M_LT: if (c == "=") begin
          put_token(psl_pkg::K_LE, '0, 0, psl_pkg::E_NONE);
          lx_mode = M_IDLE;
        end else if (c == ">") begin
          put_token(psl_pkg::K_NE, '0, 0, psl_pkg::E_NONE);
          lx_mode = M_IDLE;
        end else again = 1;
        M_GT: if (c == "=") begin
          put_token(psl_pkg::K_GE, '0, 0, psl_pkg::E_NONE);
          lx_mode = M_IDLE;
        end else again = 1;
        M_CH_OPEN: if (c == psl_pkg::QUOTE) lx_mode = M_CH_QQ;
        else begin
          lx_acc = 31'(c);
          lx_mode = M_CH_CLOSE;
        end
        M_CH_QQ: begin
          if (c != psl_pkg::QUOTE) lx_err = psl_pkg::E_CHAR;
          lx_acc = 31'(c);
          lx_mode = M_CH_CLOSE;
        end
        M_CH_CLOSE: if (c == psl_pkg::QUOTE) begin
          put_token(psl_pkg::K_CHAR, lx_acc, 0, lx_err);
          lx_mode = M_IDLE;
          lx_err = psl_pkg::E_NONE;
        end else again = 1;
        default: begin
          lx_mode = M_IDLE;
          lex_idle(c);
        end
      endcase
      if (again) begin
        lex_flush();
        lex_idle(c);
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic e);
    int g;
    g = tx_steady ? 0 : pick_gap();
    repeat (g) begin
      @(negedge clk);
      push = 0;
    end
    @(negedge clk);
    push = 1;
    in_char_in = c;
    in_end_of_text = e;
    @(posedge clk);
    while (full) @(posedge clk);
    lex_step(c, e);
    n_items++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  task automatic set_max(input logic [30:0] v);
    @(negedge clk);
    push = 0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we = 1;
    cfg_max_integer = v;
    @(negedge clk);
    cfg_we = 0;
    lx_max = v;
    n_cfg++;
  endtask

  task automatic send_lexeme();
    int r, n, i;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      if ($urandom_range(0, 2) == 0) send_text(kw_names[$urandom_range(0, 17)]);
      else begin
        n = $urandom_range(0, 3) == 0 ? $urandom_range(6, 14) : $urandom_range(1, 5);
        send_byte(8'($urandom_range("A", "Z")), 0);
        for (i = 1; i < n; i++) begin
          if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range("0", "9")), 0);
          else send_byte(8'($urandom_range("A", "Z")), 0);
        end
      end
    end else if (r < 45) begin
      n = $urandom_range(0, 2) == 0 ? $urandom_range(8, 12) : $urandom_range(1, 5);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range("0", "9")), 0);
    end else if (r < 57) begin
      send_byte(psl_pkg::QUOTE, 0);
      case ($urandom_range(0, 4))
        0: begin
          send_byte(psl_pkg::QUOTE, 0);
          send_byte(psl_pkg::QUOTE, 0);
        end
        1: begin
          send_byte(psl_pkg::QUOTE, 0);
          send_byte(8'($urandom_range(0, 255)), 0);
        end
        2: send_byte(8'($urandom_range(0, 255)), 1);
        default: send_byte(8'($urandom_range(0, 255)), 0);
      endcase
      if ($urandom_range(0, 4) != 0) send_byte(psl_pkg::QUOTE, 0);
    end else if (r < 72) send_text(ops[$urandom_range(0, 8)]);
    else if (r < 80) send_byte(singles[$urandom_range(0, 9)], 0);
    else if (r < 87) send_byte(8'($urandom_range(0, 3) == 0 ? 8'h09 : 8'h20), 0);
    else if (r < 95) send_byte(8'($urandom_range(0, 255)), 0);
    else send_byte(8'($urandom_range(0, 255)), 1);
  endtask

  task automatic random_run(input int count);
    int stop_at;
    stop_at = n_items + count;
    while (n_items < stop_at) send_lexeme();
    send_byte(8'($urandom_range(0, 255)), 1);
  endtask

  task automatic check_token();
    exp_tok_t got, want;
    got = {out_token_kind, out_const_value, out_spelling_first, out_spelling_rest,
           out_error_code, out_last_of_run};
    n_tokens++;
    if (token_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("Unexpected token: kind %0d value %0d", got.kind, got.value);
    end else begin
      want = token_q.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("Token mismatch: expected kind %0d value %0d spelling %h_%h err %0d last %0d",
                   want.kind, want.value, want.rest, want.first, want.err, want.last);
          $display("                got kind %0d value %0d spelling %h_%h err %0d last %0d",
                   got.kind, got.value, got.rest, got.first, got.err, got.last);
        end
      end
    end
  endtask

  initial begin
    int idle_left, hold_n;
    idle_left = 0;
    hold_n = 0;
    pop = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop = 0;
        hold_n++;
        if (hold_n >= 80) begin
          hold_req = 0;
          hold_n = 0;
        end
      end else if (idle_left > 0) begin
        pop = 0;
        idle_left--;
      end else begin
        pop = 1;
        if (!rx_steady && $urandom_range(0, 3) == 0) idle_left = pick_gap();
      end
      @(posedge clk);
      if (pop && !empty) check_token();
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_we || !rst_n) stall = 0;
    else stall++;
    if (stall >= 4000) begin
      $display("Timeout: no item moved for %0d cycles", stall);
      $display("tb_pascal_subset_lexer_unit: FAIL");
      $finish;
    end
  end

  row_t rows[25] = '{
    '{8'h00, 1, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"+", 0, 1, psl_pkg::K_SINGLE, 0, psl_pkg::E_NONE},
    '{psl_pkg::QUOTE, 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{psl_pkg::QUOTE, 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"x", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{psl_pkg::QUOTE, 0, 1, psl_pkg::K_CHAR, 31'h78, psl_pkg::E_CHAR},
    '{"3", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"2", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"7", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"6", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"8", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{";", 0, 1, psl_pkg::K_INT, 0, psl_pkg::E_OVERFLOW},
    '{"a", 0, 1, psl_pkg::K_OTHER, 0, psl_pkg::E_NONE},
    '{8'hFF, 0, 1, psl_pkg::K_OTHER, 0, psl_pkg::E_NONE},
    '{8'h00, 0, 1, psl_pkg::K_OTHER, 0, psl_pkg::E_NONE},
    '{psl_pkg::QUOTE, 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"A", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"B", 0, 1, psl_pkg::K_CHAR, 31'h41, psl_pkg::E_CHAR},
    '{8'hFF, 1, 1, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{":", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{"=", 0, 1, psl_pkg::K_BECOMES, 0, psl_pkg::E_NONE},
    '{"<", 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{">", 0, 1, psl_pkg::K_NE, 0, psl_pkg::E_NONE},
    '{psl_pkg::QUOTE, 0, 0, psl_pkg::K_IDENT, 0, psl_pkg::E_NONE},
    '{8'h00, 1, 1, psl_pkg::K_CHAR, 0, psl_pkg::E_CHAR}
  };

  initial begin
    int i;
    rst_n = 0;
    cfg_we = 0;
    cfg_max_integer = '0;
    push = 0;
    in_char_in = '0;
    in_end_of_text = 0;
    hold_req = 0;
    tx_steady = 0;
    rx_steady = 0;
    n_items = 0;
    n_tokens = 0;
    n_bad = 0;
    n_cfg = 0;
    stall = 0;
    lx_mode = M_IDLE;
    for (i = 0; i < 10; i++) lx_spell[i] = '0;
    lx_len = 0;
    lx_acc = '0;
    lx_err = psl_pkg::E_NONE;
    lx_max = 31'd32767;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (i = 0; i < 25; i++) begin
      send_byte(rows[i].c, rows[i].eot);
      if (rows[i].chk && (step_toks.size() == 0 || step_toks[0].kind !== rows[i].kind ||
          step_toks[0].value !== rows[i].value || step_toks[0].err !== rows[i].err)) begin
        n_bad++;
        if (n_bad <= 10) $display("Directed item %0d does not give the listed token", i);
      end
    end

    set_max(31'h7FFFFFFF);
    hold_req = 1;
    random_run(130);
    set_max(31'd1);
    random_run(130);
    set_max(31'($urandom_range(10, 99999)));
    tx_steady = 1;
    rx_steady = 1;
    random_run(130);
    tx_steady = 0;
    rx_steady = 0;
    set_max(31'($urandom_range(1, 32'h7FFFFFFF)));
    random_run(130);

    @(negedge clk);
    push = 0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (token_q.size() != 0) n_bad++;
    if (!empty) n_bad++;
    $display("Sent %0d items and checked %0d tokens across %0d integer limits.",
             n_items, n_tokens, n_cfg + 1);
    if (n_bad == 0) $display("tb_pascal_subset_lexer_unit: PASS");
    else begin
      $display("%0d failures", n_bad);
      $display("tb_pascal_subset_lexer_unit: FAIL");
    end
    $finish;
  end

endmodule
